// ===== sv/drc_pkg.sv =====
// Shared types, constants and helper functions for the depth to rainbow color pipeline.
`default_nettype none

package drc_pkg;

   localparam int DEPTH_W   = 16;
   localparam int COLOR_W   = 8;
   localparam int V_W       = 11;
   localparam int NUM_W     = 27;
   localparam int BAND_W    = 3;
   localparam int STEP_BITS = 3;

   localparam logic [DEPTH_W-1:0] MIN_DEPTH_RESET = 16'd400;
   localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 16'd1200;
   localparam logic [NUM_W-1:0]   RAMP_SPAN       = 27'd1530;
   localparam logic [COLOR_W-1:0] FULL            = 8'hff;

   typedef enum logic [0:0] {
      CSR_MIN_DEPTH = 1'b0,
      CSR_MAX_DEPTH = 1'b1
   } csr_idx_type;

   typedef enum logic [BAND_W-1:0] {
      BAND_WHITE_RED    = 3'd0,
      BAND_RED_YELLOW   = 3'd1,
      BAND_YELLOW_GREEN = 3'd2,
      BAND_GREEN_CYAN   = 3'd3,
      BAND_CYAN_BLUE    = 3'd4,
      BAND_BLUE_BLACK   = 3'd5
   } band_type;

   typedef struct packed {
      logic               black;
      logic [NUM_W-1:0]   rem;
      logic [DEPTH_W-1:0] dvs;
      logic [V_W-1:0]     quo;
   } div_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic valid;
   } flow_type;

   // One restoring division step for quotient bit k.
   function automatic div_type div_step(input div_type s, input int k);
      div_type          r;
      logic [NUM_W-1:0] shifted;
      r       = s;
      shifted = NUM_W'(s.dvs) << k;
      if (s.rem >= shifted) begin
         r.rem = s.rem - shifted;
         r.quo = r.quo | (V_W'(1) << k);
      end
      return r;
   endfunction

   function automatic rgb_type color_map(input logic black, input logic [V_W-1:0] v);
      rgb_type            c;
      logic [COLOR_W-1:0] lb;
      lb = v[COLOR_W-1:0];
      c  = '0;
      if (!black && (v != '0)) begin
         unique case (v[V_W-1:COLOR_W])
            BAND_WHITE_RED: begin
               c.red = FULL; c.green = FULL - lb; c.blue = FULL - lb;
            end
            BAND_RED_YELLOW: begin
               c.red = FULL; c.green = lb;
            end
            BAND_YELLOW_GREEN: begin
               c.red = FULL - lb; c.green = FULL;
            end
            BAND_GREEN_CYAN: begin
               c.green = FULL; c.blue = lb;
            end
            BAND_CYAN_BLUE: begin
               c.green = FULL - lb; c.blue = FULL;
            end
            BAND_BLUE_BLACK: begin
               c.blue = FULL - lb;
            end
            default: begin
               c = '0;
            end
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/drc_front.sv =====
// Front stages: offset and range check, then scaling by the ramp span.
`default_nettype none

module drc_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [drc_pkg::DEPTH_W-1:0] depth,
   input  wire logic [drc_pkg::DEPTH_W-1:0] min_depth,
   input  wire logic [drc_pkg::DEPTH_W-1:0] max_depth,
   output drc_pkg::flow_type             out_flow,
   input  wire logic                     out_ready,
   output drc_pkg::div_type              out_data
);
   import drc_pkg::*;

   logic               v1_ff, v1_in, v2_ff, v2_in;
   logic               black1_ff, black1_in;
   logic [DEPTH_W-1:0] diff_ff, diff_in, dvs1_ff, dvs1_in;
   div_type            s2_ff, s2_in;
   logic               adv1, adv2;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      v1_in     = adv1 ? in_valid : v1_ff;
      black1_in = (max_depth <= min_depth) || (depth <= min_depth);
      diff_in   = depth - min_depth;
      dvs1_in   = max_depth - min_depth;
      v2_in     = adv2 ? v1_ff : v2_ff;
      s2_in.black = black1_ff;
      s2_in.rem   = NUM_W'(diff_ff) * RAMP_SPAN;
      s2_in.dvs   = dvs1_ff;
      s2_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         black1_ff <= black1_in;
         diff_ff   <= diff_in;
         dvs1_ff   <= dvs1_in;
      end
      if (adv2) begin
         s2_ff <= s2_in;
      end
   end

   assign out_flow.valid = v2_ff;
   assign out_data       = s2_ff;

endmodule

`default_nettype wire

// ===== sv/drc_divider.sv =====
// Four-stage restoring divider giving the ramp position, three quotient bits a stage and two in the last.
`default_nettype none

module drc_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire drc_pkg::flow_type in_flow,
   output logic                   in_ready,
   input  wire drc_pkg::div_type  in_data,
   output drc_pkg::flow_type      out_flow,
   input  wire logic              out_ready,
   output drc_pkg::div_type       out_data
);
   import drc_pkg::*;

   localparam int NSTAGE = (V_W + STEP_BITS - 1) / STEP_BITS;

   logic    v_ff [NSTAGE];
   logic    v_in [NSTAGE];
   logic    adv  [NSTAGE];
   div_type st_ff [NSTAGE];
   div_type st_in [NSTAGE];
   div_type first;
   logic [NUM_W-1:0] limit;

   always_comb begin
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         if (i == NSTAGE - 1) begin
            adv[i] = !v_ff[i] || out_ready;
         end else begin
            adv[i] = !v_ff[i] || adv[i+1];
         end
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      // Positions of 1536 and above are black, which keeps the quotient within 11 bits.
      limit       = (NUM_W'(in_data.dvs) << 10) + (NUM_W'(in_data.dvs) << 9);
      first       = in_data;
      first.black = in_data.black || (in_data.rem >= limit);
      for (int i = 0; i < NSTAGE; i++) begin
         if (i == 0) begin
            v_in[i]  = adv[i] ? in_flow.valid : v_ff[i];
            st_in[i] = first;
         end else begin
            v_in[i]  = adv[i] ? v_ff[i-1] : v_ff[i];
            st_in[i] = st_ff[i-1];
         end
         for (int j = 0; j < STEP_BITS; j++) begin
            if ((V_W - 1 - i * STEP_BITS - j) >= 0) begin
               st_in[i] = div_step(st_in[i], V_W - 1 - i * STEP_BITS - j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTAGE; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            v_ff[i] <= v_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_flow.valid = v_ff[NSTAGE-1];
   assign out_data       = st_ff[NSTAGE-1];

endmodule

`default_nettype wire

// ===== sv/drc_color.sv =====
// Output stage: band and low byte to color, held in the result register.
`default_nettype none

module drc_color (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire drc_pkg::flow_type in_flow,
   output logic                   in_ready,
   input  wire drc_pkg::div_type  in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output drc_pkg::rgb_type       out_rgb
);
   import drc_pkg::*;

   logic    v_ff, v_in, adv;
   rgb_type rgb_ff, rgb_in;

   assign adv      = !v_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      v_in   = adv ? in_flow.valid : v_ff;
      rgb_in = color_map(in_data.black, in_data.quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rgb_ff <= rgb_in;
      end
   end

   assign out_valid = v_ff;
   assign out_rgb   = rgb_ff;

endmodule

`default_nettype wire

// ===== sv/depth_to_rainbow_color.sv =====
// Top level of the depth to rainbow color pipeline.
// Throughput is one beat per cycle when the output is not stalled, over seven stages:
// two front, four divider, one output.
// Synchronous reset empties the pipeline and loads min_depth 400 and max_depth 1200.
// A stalled output holds its beat while empty stages upstream keep accepting.
`default_nettype none

module depth_to_rainbow_color (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [drc_pkg::DEPTH_W-1:0] req_depth,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [drc_pkg::COLOR_W-1:0]      rsp_red,
   output logic [drc_pkg::COLOR_W-1:0]      rsp_green,
   output logic [drc_pkg::COLOR_W-1:0]      rsp_blue,
   input  wire logic                        csr_write,
   input  wire drc_pkg::csr_idx_type        csr_index,
   input  wire logic [drc_pkg::DEPTH_W-1:0] csr_wdata
);
   import drc_pkg::*;

   logic [DEPTH_W-1:0] min_depth_ff, min_depth_in, max_depth_ff, max_depth_in;
   flow_type           front_flow, div_flow;
   div_type            front_data, div_data;
   logic               div_ready, color_ready;
   rgb_type            rgb;

   always_comb begin
      min_depth_in = min_depth_ff;
      max_depth_in = max_depth_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MIN_DEPTH: min_depth_in = csr_wdata;
            CSR_MAX_DEPTH: max_depth_in = csr_wdata;
            default: begin
               min_depth_in = min_depth_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_depth_ff <= MIN_DEPTH_RESET;
         max_depth_ff <= MAX_DEPTH_RESET;
      end else begin
         min_depth_ff <= min_depth_in;
         max_depth_ff <= max_depth_in;
      end
   end

   drc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .depth     (req_depth),
      .min_depth (min_depth_ff),
      .max_depth (max_depth_ff),
      .out_flow  (front_flow),
      .out_ready (div_ready),
      .out_data  (front_data)
   );

   drc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_flow   (front_flow),
      .in_ready  (div_ready),
      .in_data   (front_data),
      .out_flow  (div_flow),
      .out_ready (color_ready),
      .out_data  (div_data)
   );

   drc_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_flow   (div_flow),
      .in_ready  (color_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rgb   (rgb)
   );

   assign rsp_red   = rgb.red;
   assign rsp_green = rgb.green;
   assign rsp_blue  = rgb.blue;

endmodule

`default_nettype wire

// ===== sv/drc_checker.sv =====
// Port-level checker for the depth to rainbow color pipeline and its bind.
`default_nettype none

module drc_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [drc_pkg::COLOR_W-1:0] rsp_red,
   input wire logic [drc_pkg::COLOR_W-1:0] rsp_green,
   input wire logic [drc_pkg::COLOR_W-1:0] rsp_blue
);
   import drc_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("stalled result beat changed");

   a_room: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled although the output register can move");

   a_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == FULL) || (rsp_green == FULL) || (rsp_blue == FULL)
         || ((rsp_red == '0) && (rsp_green == '0)))
      else $error("result color is not on the rainbow ramp");

endmodule

bind depth_to_rainbow_color drc_checker u_drc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for depth_to_rainbow_color with random beat gaps and output stalls.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import drc_pkg::*;

   localparam int unsigned RAMP_STEPS   = 1530;
   localparam int unsigned BAND_SIZE    = 256;
   localparam int unsigned BAND_COUNT   = 6;
   localparam int          MAX_WAIT     = 18;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          CYCLE_LIMIT  = 600000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_ready;
   logic [DEPTH_W-1:0]   req_depth  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready  = 1'b0;
   logic [COLOR_W-1:0]   rsp_red;
   logic [COLOR_W-1:0]   rsp_green;
   logic [COLOR_W-1:0]   rsp_blue;
   logic                 csr_write  = 1'b0;
   csr_idx_type          csr_index  = CSR_MIN_DEPTH;
   logic [DEPTH_W-1:0]   csr_wdata  = '0;

   logic [DEPTH_W-1:0]   ramp_lo    = MIN_DEPTH_RESET;
   logic [DEPTH_W-1:0]   ramp_hi    = MAX_DEPTH_RESET;
   logic [DEPTH_W-1:0]   pixel_q[$];
   rgb_type              color_q[$];
   logic                 req_taken  = 1'b0;
   logic                 rsp_taken  = 1'b0;
   logic                 steady     = 1'b0;
   int                   gap_left   = 0;
   int                   stall_left = 0;
   int                   mismatches = 0;
   int                   cycle_count = 0;

   depth_to_rainbow_color dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_depth (req_depth),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rgb_type rainbow_of(input logic [DEPTH_W-1:0] d);
      int unsigned        pos;
      logic [COLOR_W-1:0] lb;
      rgb_type            c;
      c = '0;
      if (ramp_hi > ramp_lo && d > ramp_lo) begin
         pos = (RAMP_STEPS * (d - ramp_lo)) / (ramp_hi - ramp_lo);
         lb  = pos[COLOR_W-1:0];
         if (pos != 0 && pos < BAND_SIZE * BAND_COUNT) begin
            case (band_type'(pos[10:8]))
               BAND_WHITE_RED: begin
                  c.red = FULL; c.green = FULL - lb; c.blue = FULL - lb;
               end
               BAND_RED_YELLOW: begin
                  c.red = FULL; c.green = lb;
               end
               BAND_YELLOW_GREEN: begin
                  c.red = FULL - lb; c.green = FULL;
               end
               BAND_GREEN_CYAN: begin
                  c.green = FULL; c.blue = lb;
               end
               BAND_CYAN_BLUE: begin
                  c.green = FULL - lb; c.blue = FULL;
               end
               default: begin
                  c.blue = FULL - lb;
               end
            endcase
         end
      end
      return c;
   endfunction

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [DEPTH_W-1:0] random_depth();
      int unsigned        pick;
      logic [DEPTH_W-1:0] base;
      pick = $urandom_range(0, 9);
      if (ramp_hi > ramp_lo && pick < 6) begin
         return DEPTH_W'($urandom_range(ramp_lo, ramp_hi));
      end
      if (pick < 8) begin
         base = pick[0] ? ramp_lo : ramp_hi;
         return base + DEPTH_W'($urandom_range(0, 8)) - 16'd4;
      end
      return DEPTH_W'($urandom_range(0, 65535));
   endfunction

   task automatic write_csr(input csr_idx_type idx, input logic [DEPTH_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MIN_DEPTH) begin
         ramp_lo = value;
      end else begin
         ramp_hi = value;
      end
   endtask

   task automatic set_range(input logic [DEPTH_W-1:0] lo, input logic [DEPTH_W-1:0] hi);
      write_csr(CSR_MIN_DEPTH, lo);
      write_csr(CSR_MAX_DEPTH, hi);
   endtask

   task automatic add_pixel(input logic [DEPTH_W-1:0] d);
      pixel_q.insert(pixel_q.size(), d);
   endtask

   // The block is idle once every queued beat has been sent and every color has come back.
   task automatic wait_idle();
      while (pixel_q.size() != 0 || req_valid || color_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pixel_q.size() != 0) begin
            req_valid <= 1'b1;
            req_depth <= pixel_q.pop_front();
            gap_left  <= draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int n;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_taken) begin
         n = draw_wait();
         rsp_ready  <= (n == 0);
         stall_left <= (n == 0) ? 0 : n - 1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      rgb_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            color_q.insert(color_q.size(), rainbow_of(req_depth));
         end
         if (rsp_valid && rsp_ready) begin
            if (color_q.size() == 0) begin
               $display("%0t: result beat with no color expected, got %0d/%0d/%0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               mismatches++;
            end else begin
               want = color_q.pop_front();
               if (rsp_red !== want.red) begin
                  $display("%0t: red expected %0d, got %0d", $time, want.red, rsp_red);
                  mismatches++;
               end
               if (rsp_green !== want.green) begin
                  $display("%0t: green expected %0d, got %0d", $time, want.green, rsp_green);
                  mismatches++;
               end
               if (rsp_blue !== want.blue) begin
                  $display("%0t: blue expected %0d, got %0d", $time, want.blue, rsp_blue);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [DEPTH_W-1:0] lo;
      logic [DEPTH_W-1:0] hi;
      int                 count;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset range: both ends, every band, and the black region just past the ramp.
      foreach (pixel_q[i]) begin
      end
      pixel_q = '{16'd0, 16'd65535, 16'd399, 16'd400, 16'd401, 16'd450, 16'd500,
                  16'd600, 16'd700, 16'd900, 16'd1000, 16'd1100, 16'd1199, 16'd1200,
                  16'd1201, 16'd1203, 16'd1204};
      wait_idle();

      for (int p = 0; p < 14; p++) begin
         case (p)
            0: begin lo = 16'd0;     hi = 16'd65535; end
            1: begin lo = 16'd65535; hi = 16'd0;     end
            2: begin lo = 16'd777;   hi = 16'd777;   end
            3: begin lo = 16'd0;     hi = 16'd1;     end
            4: begin lo = 16'd65534; hi = 16'd65535; end
            5: begin lo = MIN_DEPTH_RESET; hi = MAX_DEPTH_RESET; end
            default: begin
               lo = DEPTH_W'($urandom_range(0, 65000));
               if (p % 4 == 0) begin
                  hi = DEPTH_W'($urandom_range(0, 65535));
               end else begin
                  hi = lo + DEPTH_W'($urandom_range(1, 65535 - lo));
               end
            end
         endcase
         steady = (p % 3 == 2);
         set_range(lo, hi);
         if (p == 0) begin
            add_pixel(16'd0);
            add_pixel(16'd65535);
            add_pixel(16'd43);
            add_pixel(16'd42);
         end
         count = (p < 6) ? 60 : 130;
         repeat (count) add_pixel(random_depth());
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/drc_pkg.sv
sv/drc_front.sv
sv/drc_divider.sv
sv/drc_color.sv
sv/depth_to_rainbow_color.sv
sv/drc_checker.sv
test/tb.sv
